@@ rtl/arbm_pkg.sv @@
// Shared types and constants for the address range blocklist merge block.
// Holds the item and result structs, the queued command type and the
// back-end state enum. No dependencies.
package arbm_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int MAX_RANGES = 1024;

  // Table index, and counters that must also hold MAX_RANGES + 1
  localparam int IDX_W   = $clog2(MAX_RANGES);
  localparam int CNT_W   = $clog2(MAX_RANGES + 2);
  localparam int ENTRY_W = 2 * ADDR_BITS;

  localparam logic [ADDR_BITS:0] SPACE    = (ADDR_BITS + 1)'(1) << ADDR_BITS;
  localparam logic [ADDR_BITS:0] TOP_ADDR = SPACE - (ADDR_BITS + 1)'(1);

  typedef struct packed {
    logic [31:0] range_low;
    logic [31:0] range_high;
  } item_t;

  typedef struct packed {
    logic [31:0] lowest_allowed;
    logic        any_allowed;
    logic [32:0] allowed_count;
    logic        bad_range;
    logic        table_full;
  } result_t;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_BAD,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [ADDR_BITS-1:0]   lo;
    logic [ADDR_BITS-1:0]   hi;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DATA,
    S_TAIL,
    S_COMMIT,
    S_RESULT
  } state_t;

endpackage

@@ rtl/arbm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
module arbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/arbm_front.sv @@
// Front end: accepts range beats, classifies them and queues commands.
// Uses arbm_pkg for the item and command types.
module arbm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  arbm_pkg::item_t item,
  output logic           cmd_valid,
  input  logic           cmd_pop,
  output arbm_pkg::cmd_t cmd
);
  import arbm_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  cmd_t       cls;

  // Classify: swapped ends, above the space, or insert with saturated top
  always_comb begin
    cls.lo = item.range_low[ADDR_BITS-1:0];
    cls.hi = item.range_high[ADDR_BITS-1:0];
    if (item.range_low > item.range_high) begin
      cls.kind = CMD_BAD;
    end else if ({1'b0, item.range_low} > 33'(TOP_ADDR)) begin
      cls.kind = CMD_NOP;
    end else begin
      cls.kind = CMD_INSERT;
      if ({1'b0, item.range_high} > 33'(TOP_ADDR)) begin
        cls.hi = TOP_ADDR[ADDR_BITS-1:0];
      end
    end
  end

  assign item_stall = (cnt == 2'd2);
  assign push       = item_valid && !item_stall;
  assign cmd_valid  = (cnt != 2'd0);
  assign pop        = cmd_pop && cmd_valid;
  assign cmd        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/arbm_back.sv @@
// Back end: merges each queued insert into the sorted interval table by
// streaming the live bank into the spare bank, and reports the status for every command.
// Uses arbm_pkg and two arbm_ram banks.
module arbm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  arbm_pkg::cmd_t    cmd,
  output logic              result_valid,
  input  logic              result_stall,
  output arbm_pkg::result_t result
);
  import arbm_pkg::*;

  state_t state, state_next;

  logic                 bank;
  logic [CNT_W-1:0]     count;
  logic [ADDR_BITS:0]   covered;
  logic [ADDR_BITS-1:0] first_s, first_e;

  cmd_kind_t            kind;
  logic [ADDR_BITS-1:0] lo, hi, nlo, nhi;
  logic                 placed;
  logic [CNT_W-1:0]     idx, wptr;
  logic [ADDR_BITS+1:0] cov_acc;
  logic [ADDR_BITS+1:0] cov_new;
  logic [ADDR_BITS-1:0] nf_s, nf_e;
  logic                 flag_bad, flag_full;

  logic                 we;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rd0, rd1, rdata;
  logic [ADDR_BITS-1:0] ent_s, ent_e;
  logic                 d_before, d_absorb, d_place;
  logic                 last_ent, full_now, res_load;
  logic [ADDR_BITS:0]   freecnt;
  logic [ADDR_BITS-1:0] lowest;

  assign rdata = bank ? rd1 : rd0;
  assign ent_s = rdata[ENTRY_W-1:ADDR_BITS];
  assign ent_e = rdata[ADDR_BITS-1:0];

  arbm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_bank0 (
    .clk(clk), .we(we && bank), .waddr(wptr[IDX_W-1:0]), .wdata(wdata),
    .raddr(idx[IDX_W-1:0]), .rdata(rd0)
  );
  arbm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_bank1 (
    .clk(clk), .we(we && !bank), .waddr(wptr[IDX_W-1:0]), .wdata(wdata),
    .raddr(idx[IDX_W-1:0]), .rdata(rd1)
  );

  assign d_before = !placed && ({1'b0, ent_e} + 1'b1 < {1'b0, lo});
  assign d_absorb = !placed && !d_before && ({1'b0, ent_s} <= {1'b0, hi} + 1'b1);
  assign d_place  = !placed && !d_before && !d_absorb;
  assign last_ent = (idx + 1'b1 == count);
  assign full_now = (wptr > CNT_W'(MAX_RANGES));
  assign res_load = !result_valid || !result_stall;
  // Old coverage minus absorbed intervals, plus the merged interval
  assign cov_new  = cov_acc + (ADDR_BITS + 2)'(nhi) - (ADDR_BITS + 2)'(nlo)
                    + (ADDR_BITS + 2)'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd_valid) state_next = (cmd.kind == CMD_INSERT) ?
                  ((count == '0) ? S_TAIL : S_READ) : S_RESULT;
      S_READ:   state_next = S_DATA;
      S_DATA:   if (!d_place) state_next = last_ent ? S_TAIL : S_READ;
      S_TAIL:   state_next = S_COMMIT;
      S_COMMIT: state_next = S_RESULT;
      S_RESULT: if (res_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    we      = 1'b0;
    wdata   = {ent_s, ent_e};
    unique case (state)
      S_IDLE: cmd_pop = cmd_valid;
      S_DATA: begin
        we = !d_absorb;
        if (d_place) wdata = {nlo, nhi};
      end
      S_TAIL: begin
        we    = !placed;
        wdata = {nlo, nhi};
      end
      default: ;
    endcase
    // Never write past the table; such a pass is discarded anyway
    if (wptr >= CNT_W'(MAX_RANGES)) we = 1'b0;
  end

  // Status of the committed table
  always_comb begin
    freecnt = SPACE - covered;
    lowest  = '0;
    if (count != '0 && first_s == '0 && {1'b0, first_e} < TOP_ADDR) begin
      lowest = first_e + 1'b1;
    end
    if (freecnt == '0) lowest = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bank         <= 1'b0;
      count        <= '0;
      covered      <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_COMMIT && !full_now) begin
        bank    <= ~bank;
        count   <= wptr;
        covered <= cov_new[ADDR_BITS:0];
      end
      if (state == S_RESULT && res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && wptr == '0) begin
      nf_s <= wdata[ENTRY_W-1:ADDR_BITS];
      nf_e <= wdata[ADDR_BITS-1:0];
    end
    unique case (state)
      S_IDLE: begin
        kind      <= cmd.kind;
        lo        <= cmd.lo;
        hi        <= cmd.hi;
        nlo       <= cmd.lo;
        nhi       <= cmd.hi;
        placed    <= 1'b0;
        idx       <= '0;
        wptr      <= '0;
        flag_bad  <= (cmd.kind == CMD_BAD);
        flag_full <= 1'b0;
        cov_acc   <= {1'b0, covered};
      end
      S_DATA: begin
        if (d_absorb) begin
          if (ent_s < nlo) nlo <= ent_s;
          if (ent_e > nhi) nhi <= ent_e;
          cov_acc <= cov_acc - ((ADDR_BITS + 2)'(ent_e) - (ADDR_BITS + 2)'(ent_s) + 1'b1);
        end
        if (d_place) placed <= 1'b1;
        else idx <= idx + 1'b1;
        if (!d_absorb) wptr <= wptr + 1'b1;
      end
      S_TAIL: begin
        if (!placed) wptr <= wptr + 1'b1;
      end
      S_COMMIT: begin
        flag_full <= full_now;
        if (!full_now) begin
          first_s <= nf_s;
          first_e <= nf_e;
        end
      end
      S_RESULT: begin
        if (res_load) begin
          result.lowest_allowed <= 32'(lowest);
          result.any_allowed    <= (freecnt != '0);
          result.allowed_count  <= 33'(freecnt);
          result.bad_range      <= flag_bad;
          result.table_full     <= flag_full;
        end
      end
      default: ;
    endcase
  end

  // kind is kept for visibility of the current command in the merge pass
  a_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (kind == CMD_INSERT))
    else $error("merge pass running for a non-insert command");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("interval count above table size");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_range |-> !result.table_full)
    else $error("bad range and table full both set");
  a_none: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.any_allowed |->
      result.lowest_allowed == '0 && result.allowed_count == '0)
    else $error("nothing free but status nonzero");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (idx < count))
    else $error("read index beyond table");

endmodule

@@ rtl/address_range_blocklist_merge.sv @@
// Top level of the address range blocklist merge block.
// Uses arbm_pkg, arbm_front, arbm_back.
//
// Each accepted range beat yields one result beat. A range is merged into a
// sorted table of disjoint intervals by one streaming pass that reads the
// live bank and writes the spare bank, with a read state and a data state per
// stored interval, then a tail and a commit state; swapped or out-of-space
// ranges go straight to the result state. A two-entry command queue lets
// new beats be taken while a merge runs, and the result register holds a
// finished result while the next item is worked on. Tables need no clear
// after reset.
module address_range_blocklist_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  arbm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output arbm_pkg::result_t result
);
  import arbm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  arbm_front u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
  );

  arbm_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

endmodule
